@@ rtl/core/abp_pkg.sv @@
// ---------------------------------------------------------------------------
// abp_pkg
// Shared types and constants of the address breakpoint table.
// ---------------------------------------------------------------------------
package abp_pkg;

   localparam int FUNC_W   = 3;
   localparam int ADDR_W   = 32;
   localparam int BPNUM_W  = 16;
   localparam int RESNUM_W = 16;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD      = 3'd0,
      FUNC_DEL_NUM  = 3'd1,
      FUNC_DEL_ADDR = 3'd2,
      FUNC_CHECK    = 3'd3,
      FUNC_CLEAR    = 3'd4
   } func_type;

   // read address select for the entry ram
   typedef enum logic [1:0] {
      RD_NONE = 2'd0,
      RD_HEAD = 2'd1,
      RD_NEXT = 2'd2,
      RD_SKIP = 2'd3
   } rd_sel_type;

   typedef struct packed {
      logic       capture;
      logic       add_commit;
      logic       clear;
      rd_sel_type rd_sel;
      logic       advance;
      logic       set_hit;
      logic       compact_write;
      logic       count_dec;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     full;
      logic     empty;
      logic     match;
      logic     scan_last;
      logic     compact_last;
   } status_type;

endpackage

@@ rtl/core/abp_req_if.sv @@
// ---------------------------------------------------------------------------
// abp_req_if
// Request channel: one table operation per beat.
// ---------------------------------------------------------------------------
interface abp_req_if
   import abp_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [ADDR_W-1:0]   address;
   logic [BPNUM_W-1:0]  bp_number;

   modport source (output valid, func, address, bp_number, input ready);
   modport sink   (input valid, func, address, bp_number, output ready);
endinterface

@@ rtl/core/abp_rsp_if.sv @@
// ---------------------------------------------------------------------------
// abp_rsp_if
// Response channel: one result per request beat.
// ---------------------------------------------------------------------------
interface abp_rsp_if
   import abp_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                ok;
   logic [RESNUM_W-1:0] result_number;

   modport source (output valid, ok, result_number, input ready);
   modport sink   (input valid, ok, result_number, output ready);
endinterface

@@ rtl/core/abp_ram.sv @@
// ---------------------------------------------------------------------------
// abp_ram
// Generic one-write one-read ram with registered read data.
// ---------------------------------------------------------------------------
module abp_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/core/abp_ctrl.sv @@
// ---------------------------------------------------------------------------
// abp_ctrl
// Sequencer: dispatches each operation, walks the table for lookups and
// closes the gap after a delete.
// ---------------------------------------------------------------------------
module abp_ctrl
   import abp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_COMPACT,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_FINISH;
            case (status.func)
               FUNC_ADD: begin
                  cmd.add_commit = !status.full;
               end
               FUNC_CLEAR: begin
                  cmd.clear = 1'b1;
               end
               FUNC_DEL_NUM, FUNC_DEL_ADDR, FUNC_CHECK: begin
                  if (!status.empty) begin
                     cmd.rd_sel = RD_HEAD;
                     state_in   = ST_SCAN;
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_SCAN: begin
            if (status.match) begin
               cmd.set_hit = 1'b1;
               if (status.func == FUNC_CHECK) begin
                  state_in = ST_FINISH;
               end else if (status.scan_last) begin
                  cmd.count_dec = 1'b1;
                  state_in      = ST_FINISH;
               end else begin
                  // hit stays at idx, fetch the next older entry to pull up
                  cmd.rd_sel = RD_NEXT;
                  state_in   = ST_COMPACT;
               end
            end else if (status.scan_last) begin
               state_in = ST_FINISH;
            end else begin
               cmd.rd_sel  = RD_NEXT;
               cmd.advance = 1'b1;
            end
         end
         ST_COMPACT: begin
            cmd.compact_write = 1'b1;
            if (status.compact_last) begin
               cmd.count_dec = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               cmd.rd_sel  = RD_SKIP;
               cmd.advance = 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule

@@ rtl/core/abp_datapath.sv @@
// ---------------------------------------------------------------------------
// abp_datapath
// Entry ram kept as a ring (newest at head), fill count, number counter,
// comparator and result registers.
// ---------------------------------------------------------------------------
module abp_datapath
   import abp_pkg::*;
#(
   parameter int TABLE_DEPTH = 16,
   parameter int NUMBER_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic [FUNC_W-1:0]    req_func,
   input  logic [ADDR_W-1:0]    req_address,
   input  logic [BPNUM_W-1:0]   req_bp_number,
   output logic                 rsp_ok,
   output logic [RESNUM_W-1:0]  rsp_result_number
);
   localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int OFS_W   = CNT_W + 1;
   localparam int ENTRY_W = ADDR_W + NUMBER_BITS;

   logic [FUNC_W-1:0]      op_func_ff;
   logic [ADDR_W-1:0]      op_addr_ff;
   logic [NUMBER_BITS-1:0] op_num_ff;
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [CNT_W-1:0]       count_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic [NUMBER_BITS-1:0] counter_ff;
   logic                   res_ok_ff;
   logic [NUMBER_BITS-1:0] res_num_ff;
   logic                   rsp_ok_ff;
   logic [RESNUM_W-1:0]    rsp_num_ff;

   logic [NUMBER_BITS+BPNUM_W-1:0]  bp_wide;
   logic [NUMBER_BITS+RESNUM_W-1:0] res_wide;
   logic [OFS_W-1:0]       idx_ext, count_ext, rd_ofs;
   logic [IDX_W-1:0]       rd_addr, wr_addr, hole_addr;
   logic                   wr_en;
   logic [ENTRY_W-1:0]     wr_data, rd_data;
   logic [ADDR_W-1:0]      rd_address;
   logic [NUMBER_BITS-1:0] rd_number;

   // logical position to ram address; head and offset both stay below the depth
   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                             input logic [OFS_W-1:0] ofs);
      logic [OFS_W-1:0] sum;
      sum = OFS_W'(head) + ofs;
      if (sum >= OFS_W'(TABLE_DEPTH)) begin
         sum = sum - OFS_W'(TABLE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   assign bp_wide   = {{NUMBER_BITS{1'b0}}, req_bp_number};
   assign idx_ext   = OFS_W'(idx_ff);
   assign count_ext = OFS_W'(count_ff);
   assign head_in   = (head_ff == '0) ? IDX_W'(TABLE_DEPTH - 1) : head_ff - 1'b1;

   always_comb begin
      case (cmd.rd_sel)
         RD_HEAD: rd_ofs = '0;
         RD_NEXT: rd_ofs = idx_ext + OFS_W'(1);
         RD_SKIP: rd_ofs = idx_ext + OFS_W'(2);
         default: rd_ofs = '0;
      endcase
   end

   assign rd_addr   = phys(head_ff, rd_ofs);
   assign hole_addr = phys(head_ff, idx_ext);

   assign wr_en   = cmd.add_commit || cmd.compact_write;
   assign wr_addr = cmd.add_commit ? head_in : hole_addr;
   assign wr_data = cmd.add_commit ? {op_addr_ff, counter_ff} : rd_data;

   abp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_address = rd_data[ENTRY_W-1:NUMBER_BITS];
   assign rd_number  = rd_data[NUMBER_BITS-1:0];

   always_comb begin
      status.func         = func_type'(op_func_ff);
      status.full         = (count_ff == CNT_W'(TABLE_DEPTH));
      status.empty        = (count_ff == '0);
      status.match        = (func_type'(op_func_ff) == FUNC_DEL_NUM) ?
                            (rd_number == op_num_ff) : (rd_address == op_addr_ff);
      status.scan_last    = (idx_ext + OFS_W'(1)) >= count_ext;
      status.compact_last = (idx_ext + OFS_W'(2)) >= count_ext;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         count_ff   <= '0;
         counter_ff <= '0;
      end else if (cmd.clear) begin
         count_ff   <= '0;
         counter_ff <= '0;
      end else if (cmd.add_commit) begin
         head_ff    <= head_in;
         count_ff   <= count_ff + 1'b1;
         counter_ff <= counter_ff + 1'b1;
      end else if (cmd.count_dec) begin
         count_ff   <= count_ff - 1'b1;
      end
   end

   // operand, scan and result registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_func_ff <= req_func;
         op_addr_ff <= req_address;
         op_num_ff  <= bp_wide[NUMBER_BITS-1:0];
         idx_ff     <= '0;
         res_ok_ff  <= 1'b0;
         res_num_ff <= '0;
      end else begin
         if (cmd.advance) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.add_commit) begin
            res_ok_ff  <= 1'b1;
            res_num_ff <= counter_ff;
         end else if (cmd.clear) begin
            res_ok_ff  <= 1'b1;
         end else if (cmd.set_hit) begin
            res_ok_ff  <= 1'b1;
            res_num_ff <= rd_number;
         end
      end
   end

   assign res_wide = {{RESNUM_W{1'b0}}, res_num_ff};

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ok_ff  <= res_ok_ff;
         rsp_num_ff <= res_wide[RESNUM_W-1:0];
      end
   end

   assign rsp_ok            = rsp_ok_ff;
   assign rsp_result_number = rsp_num_ff;
endmodule

@@ rtl/core/address_breakpoint_table_core.sv @@
// ---------------------------------------------------------------------------
// address_breakpoint_table_core
// Table of address breakpoints with add, delete, check and clear.
// ---------------------------------------------------------------------------
// One request is worked at a time. Add, clear and unused codes go from
// dispatch straight to the finish state. Delete and check scan the entries
// newest first, one entry per cycle through the single read port of the entry
// ram; on an empty table they skip the scan. A delete then moves every older
// entry up by one, one entry per cycle. The next request is taken once the
// result sits in the output register. No clearing pass is needed after reset.
module address_breakpoint_table_core
   import abp_pkg::*;
#(
   parameter int TABLE_DEPTH = 16,
   parameter int NUMBER_BITS = 16
) (
   input  logic     clock,
   input  logic     reset,
   abp_req_if.sink  req_bus,
   abp_rsp_if.source rsp_bus
);
   cmd_type    cmd;
   status_type status;

   abp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   abp_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .NUMBER_BITS (NUMBER_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_func          (req_bus.func),
      .req_address       (req_bus.address),
      .req_bp_number     (req_bus.bp_number),
      .rsp_ok            (rsp_bus.ok),
      .rsp_result_number (rsp_bus.result_number)
   );

`ifndef NO_ASSERTIONS
   // an add never writes into a full table
   a_no_add_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.add_commit |-> !status.full)
      else $error("add committed to a full table");

   // a waiting result is never overwritten
   a_no_load_over_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |-> !cmd.load_rsp)
      else $error("result loaded over a pending beat");

   // one request at a time: no second beat right after an accepted one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request taken while one is in flight");

   // compaction only runs on a non-empty table
   a_compact_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.compact_write |-> !status.empty)
      else $error("compaction on an empty table");
`endif
endmodule
